/* hdl/mer_pkg.sv */
// shared types and constants for the midpoint ellipse rasterizer
// holds controller states, datapath command/status structs and operation codes
// no dependencies
package mer_pkg;

    // input command codes carried on the input channel user bit
    localparam logic CMD_START = 1'b0;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_AA,
        ST_LD_BB,
        ST_LD_A2B,
        ST_LD_FIN1,
        ST_LD_FIN2,
        ST_R1_XA,
        ST_R1_KB,
        ST_R1_XB,
        ST_R1_Y,
        ST_R1_KAB,
        ST_R2I_0,
        ST_R2I_1,
        ST_R2I_2,
        ST_R2I_3,
        ST_R2I_4,
        ST_R2_DISP,
        ST_R2_X,
        ST_R2_Y,
        ST_R2_KA,
        ST_EMIT,
        ST_EMIT_NONE
    } state_t;

    // operand pairs for the shared multiplier
    typedef enum logic [2:0] {
        MS_HOLD,
        MS_AA,
        MS_BB,
        MS_A2B,
        MS_TX,
        MS_TY,
        MS_A2B2
    } mul_sel_t;

    // decision register updates, one wide add each
    typedef enum logic [3:0] {
        DO_HOLD,
        DO_INIT,
        DO_LOAD_MUL,
        DO_ADD_2MUL,
        DO_SUB_4MUL,
        DO_ADD_4P,
        DO_SUB_4Q,
        DO_ADD_4B2,
        DO_ADD_4SAB,
        DO_ADD_8A2
    } dec_op_t;

    // scratch register updates
    typedef enum logic [1:0] {
        TO_HOLD,
        TO_PB,
        TO_QA
    } tmp_op_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     a2_ld;
        logic     b2_ld;
        logic     pq_init;
        dec_op_t  dec_op;
        tmp_op_t  tmp_op;
        logic     step_x;
        logic     step_y;
        logic     set_r2;
        logic     emit;
        logic     emit_pt;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic p_lt_q;
        logic dec_pos;
        logic active;
        logic in_r2;
        logic out_free;
    } dp_stat_t;

endpackage

/* hdl/midpoint_ellipse_rasterizer.sv */
// top level of the midpoint ellipse rasterizer
// joins mer_ctrl and mer_datapath to the stream ports; uses mer_pkg
//
//  channel | direction | tdata (low bit up)                      | tuser       | tlast
//  s_axis  | in        | center_x, center_y, semi_axis_a, semi_axis_b | cmd    | -
//  m_axis  | out       | right_x, left_x, upper_y, lower_y       | point_valid | last_point
//
// per item: a start, a region one step (with or without a y move), a region two step,
//   a step that changes region or a step while idle, sequenced through the single
//   decision adder and the one shared multiplier; no new item is taken until the
//   result of the last has been handed to the output register
// reset: synchronous, aresetn low; leaves the block idle with no result held
// stalls: a held result waits in the output register while the next
//   item is taken; only the hand-off of a new result waits for it to drain
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int  COORD_BITS = 12,
    parameter int  AXIS_BITS  = 10,
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 2 * AXIS_BITS + 7) / 8) * 8,
    localparam int OUT_W      = COORD_BITS + 1,
    localparam int OUT_DATA_W = ((4 * OUT_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // center_x, center_y, semi_axis_a, semi_axis_b
    input  logic                  s_axis_tuser,  // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // right_x, left_x, upper_y, lower_y
    output logic                  m_axis_tuser,  // point_valid
    output logic                  m_axis_tlast   // last_point
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    logic [COORD_BITS-1:0] in_cx, in_cy;
    logic [AXIS_BITS-1:0]  in_a, in_b;
    logic [OUT_W-1:0]      rx, lx, uy, ly;
    logic                  pt_valid, pt_last;

    // unpack the input transaction
    assign in_cx = s_axis_tdata[COORD_BITS-1:0];
    assign in_cy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_a  = s_axis_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS];
    assign in_b  = s_axis_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS];

    mer_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_cmd   (s_axis_tuser),
        .s_ready (s_axis_tready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    mer_datapath #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_center_x     (in_cx),
        .in_center_y     (in_cy),
        .in_axis_a       (in_a),
        .in_axis_b       (in_b),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_point_valid (pt_valid),
        .out_last        (pt_last),
        .out_right_x     (rx),
        .out_left_x      (lx),
        .out_upper_y     (uy),
        .out_lower_y     (ly)
    );

    // pack the result transaction
    assign m_axis_tdata = OUT_DATA_W'({ly, uy, lx, rx});
    assign m_axis_tuser = pt_valid;
    assign m_axis_tlast = pt_last;

    // the block is busy in the cycle after it accepts an item
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after an accept");

    // a new result only appears after the controller left idle
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a busy cycle");

    // final point set is a real point set on the horizontal axis
    a_last_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser && (m_axis_tdata[3*OUT_W-1:2*OUT_W] ==
                              m_axis_tdata[4*OUT_W-1:3*OUT_W])))
        else $error("last point set with nonzero y offset");

    // a result without a point set carries all zero fields
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> ((m_axis_tdata == '0) && !m_axis_tlast))
        else $error("invalid result carries data");

endmodule

/* hdl/mer_ctrl.sv */
// controller state machine for the midpoint ellipse rasterizer
// sequences the datapath's adds and multiplies state by state; uses mer_pkg
module mer_ctrl
    import mer_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_cmd,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MS_HOLD;
        cmd.dec_op  = DO_HOLD;
        cmd.tmp_op  = TO_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    priority if (s_cmd == CMD_START) begin
                        cmd.load   = 1'b1;
                        state_next = ST_LD_AA;
                    end else if (!stat.active) begin
                        state_next = ST_EMIT_NONE;
                    end else if (stat.in_r2) begin
                        state_next = stat.dec_pos ? ST_R2_Y : ST_R2_X;
                    end else if (stat.p_lt_q) begin
                        state_next = stat.dec_pos ? ST_R1_XB : ST_R1_XA;
                    end else begin
                        state_next = ST_R2I_0;
                    end
                end
            end
            // start: squares, a^2*b, then the initial decision
            ST_LD_AA: begin
                cmd.mul_sel = MS_AA;
                state_next  = ST_LD_BB;
            end
            ST_LD_BB: begin
                cmd.a2_ld   = 1'b1;
                cmd.mul_sel = MS_BB;
                state_next  = ST_LD_A2B;
            end
            ST_LD_A2B: begin
                cmd.b2_ld   = 1'b1;
                cmd.mul_sel = MS_A2B;
                state_next  = ST_LD_FIN1;
            end
            ST_LD_FIN1: begin
                cmd.dec_op  = DO_INIT;
                cmd.pq_init = 1'b1;
                state_next  = ST_LD_FIN2;
            end
            ST_LD_FIN2: begin
                cmd.dec_op = DO_SUB_4MUL;
                state_next = ST_EMIT;
            end
            // region one, x move only
            ST_R1_XA: begin
                cmd.dec_op = DO_ADD_4P;
                cmd.step_x = 1'b1;
                state_next = ST_R1_KB;
            end
            ST_R1_KB: begin
                cmd.dec_op = DO_ADD_4B2;
                state_next = ST_EMIT;
            end
            // region one, diagonal move
            ST_R1_XB: begin
                cmd.dec_op = DO_ADD_4P;
                cmd.step_x = 1'b1;
                state_next = ST_R1_Y;
            end
            ST_R1_Y: begin
                cmd.dec_op = DO_SUB_4Q;
                cmd.step_y = 1'b1;
                state_next = ST_R1_KAB;
            end
            ST_R1_KAB: begin
                cmd.dec_op = DO_ADD_4SAB;
                state_next = ST_EMIT;
            end
            // region change: rebuild decision from products
            ST_R2I_0: begin
                cmd.tmp_op = TO_PB;
                state_next = ST_R2I_1;
            end
            ST_R2I_1: begin
                cmd.mul_sel = MS_TX;
                cmd.tmp_op  = TO_QA;
                state_next  = ST_R2I_2;
            end
            ST_R2I_2: begin
                cmd.dec_op  = DO_LOAD_MUL;
                cmd.mul_sel = MS_TY;
                state_next  = ST_R2I_3;
            end
            ST_R2I_3: begin
                cmd.dec_op  = DO_ADD_2MUL;
                cmd.mul_sel = MS_A2B2;
                state_next  = ST_R2I_4;
            end
            ST_R2I_4: begin
                cmd.dec_op = DO_SUB_4MUL;
                cmd.set_r2 = 1'b1;
                state_next = ST_R2_DISP;
            end
            ST_R2_DISP: begin
                state_next = stat.dec_pos ? ST_R2_Y : ST_R2_X;
            end
            // region two moves
            ST_R2_X: begin
                cmd.dec_op = DO_ADD_4P;
                cmd.step_x = 1'b1;
                state_next = ST_R2_Y;
            end
            ST_R2_Y: begin
                cmd.dec_op = DO_SUB_4Q;
                cmd.step_y = 1'b1;
                state_next = ST_R2_KA;
            end
            ST_R2_KA: begin
                cmd.dec_op = DO_ADD_8A2;
                state_next = ST_EMIT;
            end
            // hand result to the output register
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.emit_pt = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_EMIT_NONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/mer_datapath.sv */
// datapath for the midpoint ellipse rasterizer: offsets, incremental terms,
// decision adder, shared multiplier and output register; uses mer_pkg
module mer_datapath
    import mer_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int AXIS_BITS  = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [COORD_BITS-1:0] in_center_x,
    input  logic [COORD_BITS-1:0] in_center_y,
    input  logic [AXIS_BITS-1:0]  in_axis_a,
    input  logic [AXIS_BITS-1:0]  in_axis_b,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  out_point_valid,
    output logic                  out_last,
    output logic [COORD_BITS:0]   out_right_x,
    output logic [COORD_BITS:0]   out_left_x,
    output logic [COORD_BITS:0]   out_upper_y,
    output logic [COORD_BITS:0]   out_lower_y
);

    localparam int X_W   = AXIS_BITS + 1;
    localparam int SQ_W  = 2 * AXIS_BITS;
    localparam int PQ_W  = 3 * AXIS_BITS + 3;
    localparam int MA_W  = 3 * AXIS_BITS + 2;
    localparam int MB_W  = 2 * AXIS_BITS;
    localparam int MUL_W = 4 * AXIS_BITS + 4;
    localparam int DEC_W = 4 * AXIS_BITS + 8;
    localparam int OUT_W = COORD_BITS + 1;
    localparam int SUM_W = ((COORD_BITS > X_W) ? COORD_BITS : X_W) + 1;

    // latched item and derived squares
    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [AXIS_BITS-1:0]  a_reg, b_reg;
    logic [SQ_W-1:0]       a2_reg, b2_reg;
    logic [SQ_W:0]         sab_reg;

    // walk state: p = 2b^2(x+1), q = a^2(2y-1), decision scaled by four
    logic [X_W-1:0]   x_reg, x_next;
    logic [X_W-1:0]   y_reg, y_next;
    logic [PQ_W-1:0]  p_reg, p_next;
    logic [PQ_W-1:0]  q_reg, q_next;
    logic [DEC_W-1:0] dec_reg, dec_next;
    logic [MA_W-1:0]  tmp_reg, tmp_next;
    logic [MUL_W-1:0] mul_reg, mul_next;
    logic             active_reg, active_next;
    logic             r2_reg, r2_next;

    logic [X_W-1:0]       y_m1;
    logic [PQ_W-1:0]      p_minus_b2, q_minus_a2;
    logic [MA_W-1:0]      mul_op_a;
    logic [MB_W-1:0]      mul_op_b;
    logic [MA_W+MB_W-1:0] mul_full;
    logic [DEC_W-1:0]     p_ext, q_ext;
    logic [DEC_W-1:0]     dec_base, dec_opnd, dec_sum;
    logic                 dec_sub;
    logic                 y_zero;

    // output register
    logic             out_valid_reg;
    logic             out_pt_reg;
    logic             out_last_reg;
    logic [OUT_W-1:0] out_rx_reg, out_lx_reg, out_uy_reg, out_ly_reg;
    logic [SUM_W-1:0] cx_ext, cy_ext, x_ext, y_ext;
    logic [SUM_W-1:0] rx_sum, lx_sum, uy_sum, ly_sum;

    assign y_m1       = y_reg - X_W'(1);
    assign y_zero     = (y_reg == '0);
    assign p_minus_b2 = p_reg - PQ_W'(b2_reg);
    assign q_minus_a2 = q_reg - PQ_W'(a2_reg);

    // shared multiplier operand selection
    always_comb begin
        unique case (cmd.mul_sel)
            MS_AA: begin
                mul_op_a = MA_W'(a_reg);
                mul_op_b = MB_W'(a_reg);
            end
            MS_BB: begin
                mul_op_a = MA_W'(b_reg);
                mul_op_b = MB_W'(b_reg);
            end
            MS_A2B: begin
                mul_op_a = MA_W'(a2_reg);
                mul_op_b = MB_W'(b_reg);
            end
            MS_TX: begin
                mul_op_a = tmp_reg;
                mul_op_b = MB_W'({x_reg, 1'b1});
            end
            MS_TY: begin
                mul_op_a = tmp_reg;
                mul_op_b = MB_W'(y_m1);
            end
            MS_A2B2: begin
                mul_op_a = MA_W'(a2_reg);
                mul_op_b = MB_W'(b2_reg);
            end
            MS_HOLD: begin
                mul_op_a = '0;
                mul_op_b = '0;
            end
            default: begin
                mul_op_a = '0;
                mul_op_b = '0;
            end
        endcase
    end

    assign mul_full = mul_op_a * mul_op_b;
    assign mul_next = (cmd.mul_sel == MS_HOLD) ? mul_reg : mul_full[MUL_W-1:0];

    // decision adder operands
    assign p_ext = {{(DEC_W - PQ_W){p_reg[PQ_W-1]}}, p_reg};
    assign q_ext = {{(DEC_W - PQ_W){q_reg[PQ_W-1]}}, q_reg};

    always_comb begin
        dec_base = dec_reg;
        dec_opnd = '0;
        dec_sub  = 1'b0;
        unique case (cmd.dec_op)
            DO_HOLD: begin
                dec_opnd = '0;
            end
            DO_INIT: begin
                dec_base = DEC_W'(a2_reg);
                dec_opnd = DEC_W'({b2_reg, 2'b00});
            end
            DO_LOAD_MUL: begin
                dec_base = '0;
                dec_opnd = DEC_W'(mul_reg);
            end
            DO_ADD_2MUL: begin
                dec_opnd = DEC_W'({mul_reg, 1'b0});
            end
            DO_SUB_4MUL: begin
                dec_opnd = DEC_W'({mul_reg, 2'b00});
                dec_sub  = 1'b1;
            end
            DO_ADD_4P: begin
                dec_opnd = {p_ext[DEC_W-3:0], 2'b00};
            end
            DO_SUB_4Q: begin
                dec_opnd = {q_ext[DEC_W-3:0], 2'b00};
                dec_sub  = 1'b1;
            end
            DO_ADD_4B2: begin
                dec_opnd = DEC_W'({b2_reg, 2'b00});
            end
            DO_ADD_4SAB: begin
                dec_opnd = DEC_W'({sab_reg, 2'b00});
            end
            DO_ADD_8A2: begin
                dec_opnd = DEC_W'({a2_reg, 3'b000});
            end
            default: begin
                dec_opnd = '0;
            end
        endcase
    end

    assign dec_sum  = dec_base + (dec_sub ? ~dec_opnd : dec_opnd) + DEC_W'(dec_sub);
    assign dec_next = dec_sum;

    // scratch operand for the region change products
    always_comb begin
        unique case (cmd.tmp_op)
            TO_PB:   tmp_next = p_minus_b2[MA_W-1:0];
            TO_QA:   tmp_next = q_minus_a2[MA_W-1:0];
            TO_HOLD: tmp_next = tmp_reg;
            default: tmp_next = tmp_reg;
        endcase
    end

    // offsets and incremental terms
    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        p_next = p_reg;
        q_next = q_reg;
        if (cmd.load) begin
            x_next = '0;
            y_next = X_W'(in_axis_b);
        end
        if (cmd.step_x) begin
            x_next = x_reg + X_W'(1);
            p_next = p_reg + PQ_W'({b2_reg, 1'b0});
        end
        if (cmd.step_y) begin
            y_next = y_m1;
            q_next = q_reg - PQ_W'({a2_reg, 1'b0});
        end
        if (cmd.pq_init) begin
            p_next = PQ_W'({b2_reg, 1'b0});
            q_next = PQ_W'({mul_reg, 1'b0}) - PQ_W'(a2_reg);
        end
    end

    // drawing and region flags
    always_comb begin
        active_next = active_reg;
        r2_next     = r2_reg;
        if (cmd.load) begin
            active_next = 1'b1;
            r2_next     = 1'b0;
        end else if (cmd.emit && cmd.emit_pt && y_zero) begin
            active_next = 1'b0;
        end
        if (cmd.set_r2) begin
            r2_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            r2_reg     <= 1'b0;
        end else begin
            active_reg <= active_next;
            r2_reg     <= r2_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= in_center_x;
            cy_reg <= in_center_y;
            a_reg  <= in_axis_a;
            b_reg  <= in_axis_b;
        end
        if (cmd.a2_ld) begin
            a2_reg <= mul_reg[SQ_W-1:0];
        end
        if (cmd.b2_ld) begin
            b2_reg <= mul_reg[SQ_W-1:0];
        end
        if (cmd.pq_init) begin
            sab_reg <= (SQ_W + 1)'(a2_reg) + (SQ_W + 1)'(b2_reg);
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        dec_reg <= dec_next;
        tmp_reg <= tmp_next;
        mul_reg <= mul_next;
    end

    // point set from centre and offsets, wrapped to the output width
    assign cx_ext = {{(SUM_W - COORD_BITS){cx_reg[COORD_BITS-1]}}, cx_reg};
    assign cy_ext = {{(SUM_W - COORD_BITS){cy_reg[COORD_BITS-1]}}, cy_reg};
    assign x_ext  = {{(SUM_W - X_W){1'b0}}, x_reg};
    assign y_ext  = {{(SUM_W - X_W){1'b0}}, y_reg};
    assign rx_sum = cx_ext + x_ext;
    assign lx_sum = cx_ext - x_ext;
    assign uy_sum = cy_ext + y_ext;
    assign ly_sum = cy_ext - y_ext;

    // output register, freed when the downstream side takes the transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_pt_reg   <= cmd.emit_pt;
            out_last_reg <= cmd.emit_pt && y_zero;
            out_rx_reg   <= cmd.emit_pt ? rx_sum[OUT_W-1:0] : '0;
            out_lx_reg   <= cmd.emit_pt ? lx_sum[OUT_W-1:0] : '0;
            out_uy_reg   <= cmd.emit_pt ? uy_sum[OUT_W-1:0] : '0;
            out_ly_reg   <= cmd.emit_pt ? ly_sum[OUT_W-1:0] : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_point_valid = out_pt_reg;
    assign out_last        = out_last_reg;
    assign out_right_x     = out_rx_reg;
    assign out_left_x      = out_lx_reg;
    assign out_upper_y     = out_uy_reg;
    assign out_lower_y     = out_ly_reg;

    // status to the controller
    assign stat.p_lt_q   = ($signed(p_reg) < $signed(q_reg));
    assign stat.dec_pos  = !dec_reg[DEC_W-1] && (dec_reg != '0);
    assign stat.active   = active_reg;
    assign stat.in_r2    = r2_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

/* test/tb_midpoint_ellipse_rasterizer.sv */
`timescale 1ns / 1ps
// self-checking testbench for midpoint_ellipse_rasterizer: directed and random ellipse walks
// predicts each point set from its own model of the midpoint walk; uses mer_pkg
module tb_midpoint_ellipse_rasterizer
    import mer_pkg::*;
();

    localparam int COORD_W    = 12;
    localparam int AXIS_W     = 10;
    localparam int PT_W       = COORD_W + 1;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;
    localparam int DRAIN_CYCLES = 20;
    localparam logic CMD_STEP = ~CMD_START;

    typedef struct packed {
        logic            valid;
        logic [PT_W-1:0] right_x;
        logic [PT_W-1:0] left_x;
        logic [PT_W-1:0] upper_y;
        logic [PT_W-1:0] lower_y;
        logic            last;
    } point_set_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // walk state mirrored from the block
    bit     drawing;
    bit     region_two;
    longint off_x, off_y, decision_x4;
    longint cen_x, cen_y, axis_a, axis_b;

    point_set_t pending_points[$];
    int         mismatch_count = 0;
    int         items_sent = 0;
    int         tx_idle_pct = 13;
    int         rx_idle_pct = 67;
    int         rx_hold_cycles = 0;

    midpoint_ellipse_rasterizer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // predict the point set for one accepted transaction
    task automatic advance_ellipse(input logic cmd, input logic signed [COORD_W-1:0] cx,
                                   input logic signed [COORD_W-1:0] cy,
                                   input logic [AXIS_W-1:0] a, input logic [AXIS_W-1:0] b);
        point_set_t ps;
        longint     a2, b2;
        bit         moved;
        ps = '0;
        moved = 1'b0;
        if (cmd == CMD_START) begin
            cen_x = longint'(cx);
            cen_y = longint'(cy);
            axis_a = longint'(a);
            axis_b = longint'(b);
            a2 = axis_a * axis_a;
            b2 = axis_b * axis_b;
            off_x = 0;
            off_y = axis_b;
            region_two = 1'b0;
            decision_x4 = 4 * b2 + a2 * (1 - 4 * axis_b);
            drawing = 1'b1;
            moved = 1'b1;
        end else if (drawing) begin
            a2 = axis_a * axis_a;
            b2 = axis_b * axis_b;
            // region one while the slope is shallow
            if (!region_two && (2 * b2 * (off_x + 1) < a2 * (2 * off_y - 1))) begin
                if (decision_x4 <= 0) begin
                    decision_x4 += 4 * b2 * (2 * off_x + 3);
                end else begin
                    decision_x4 += 4 * b2 * (2 * off_x + 3) + 4 * a2 * (2 - 2 * off_y);
                    off_y -= 1;
                end
                off_x += 1;
            end else begin
                // region change forms the region two decision, then moves in the same step
                if (!region_two) begin
                    region_two = 1'b1;
                    decision_x4 = b2 * (2 * off_x + 1) * (2 * off_x + 1)
                                + 4 * a2 * (off_y - 1) * (off_y - 1) - 4 * a2 * b2;
                end
                if (decision_x4 <= 0) begin
                    decision_x4 += 4 * (b2 * (2 * off_x + 2) + a2 * (3 - 2 * off_y));
                    off_x += 1;
                end else begin
                    decision_x4 += 4 * a2 * (3 - 2 * off_y);
                end
                off_y -= 1;
            end
            moved = 1'b1;
        end
        if (moved) begin
            ps.valid   = 1'b1;
            ps.right_x = PT_W'(cen_x + off_x);
            ps.left_x  = PT_W'(cen_x - off_x);
            ps.upper_y = PT_W'(cen_y + off_y);
            ps.lower_y = PT_W'(cen_y - off_y);
            ps.last    = (off_y == 0);
            if (off_y == 0)
                drawing = 1'b0;
        end
        pending_points.push_back(ps);
    endtask

    // drive one transaction, with an occasional random gap ahead of it
    task automatic send_item(input logic cmd, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy,
                             input logic [AXIS_W-1:0] a, input logic [AXIS_W-1:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, b, a, cy, cx};
        do @(posedge aclk); while (!s_axis_tready);
        advance_ellipse(cmd, cx, cy, a, b);
        items_sent++;
    endtask

    // step with random content in the unused fields
    task automatic send_step();
        send_item(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom),
                  AXIS_W'($urandom), AXIS_W'($urandom));
    endtask

    // start an ellipse and step it until done or the step budget runs out
    task automatic run_drawing(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                               input logic [AXIS_W-1:0] a, input logic [AXIS_W-1:0] b,
                               input int max_steps);
        int n;
        n = 0;
        send_item(CMD_START, cx, cy, a, b);
        while (drawing && n < max_steps) begin
            send_step();
            n++;
        end
    endtask

    // stop offering and wait for every expected point set
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge aclk);
    endtask

    // receiver: long hold-offs first, random stalls otherwise
    always @(posedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string field_name, input logic [PT_W-1:0] exp_val,
                               input logic [PT_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s expected %0d got %0d", $time, field_name,
                     $signed(exp_val), $signed(act_val));
            mismatch_count++;
        end
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        point_set_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected point set, expected none got tdata %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_points.pop_front();
                check_field("point_valid", PT_W'(want.valid), PT_W'(m_axis_tuser));
                check_field("right_x", want.right_x, m_axis_tdata[PT_W-1:0]);
                check_field("left_x", want.left_x, m_axis_tdata[2*PT_W-1:PT_W]);
                check_field("upper_y", want.upper_y, m_axis_tdata[3*PT_W-1:2*PT_W]);
                check_field("lower_y", want.lower_y, m_axis_tdata[4*PT_W-1:3*PT_W]);
                check_field("last_point", PT_W'(want.last), PT_W'(m_axis_tlast));
            end
        end
    end

    // steps before any start give invalid results
    task automatic test_idle_step();
        send_step();
        send_item(CMD_STEP, '1, '1, '1, '1);
    endtask

    // coordinate and axis extremes, partial walks
    task automatic test_extremes();
        run_drawing(12'h800, 12'h800, 10'd1023, 10'd1023, 2);
        run_drawing(12'h7FF, 12'h7FF, 10'd1023, 10'd1023, 2);
    endtask

    // zero axes: start point set is last, a further step is idle
    task automatic test_degenerate();
        send_item(CMD_START, 12'd0, 12'd0, 10'd0, 10'd0);
        send_step();
        send_item(CMD_START, 12'd100, -12'sd100, 10'd7, 10'd0);
        run_drawing(12'd5, 12'd5, 10'd0, 10'd3, 8);
    endtask

    // flat ellipse that reaches y zero in region one
    task automatic test_region_one_end();
        run_drawing(-12'sd30, 12'd40, 10'd10, 10'd1, 20);
    endtask

    // full walk through the region change
    task automatic test_region_change();
        run_drawing(12'd0, 12'd0, 10'd4, 10'd3, 12);
    endtask

    // a new start in the middle of a walk restarts it
    task automatic test_restart();
        run_drawing(12'd10, 12'd20, 10'd5, 10'd5, 2);
        run_drawing(-12'sd7, 12'd3, 10'd2, 10'd2, 8);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        run_drawing(COORD_W'($urandom), COORD_W'($urandom), 10'd9, 10'd6, 40);
        wait_drained();
    endtask

    // random walks: mostly complete, some cut short, some noise
    task automatic test_random_drawings(input int n_items);
        int target, pick, size_pick;
        logic [AXIS_W-1:0] a, b;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(4, 1))
                    send_item(1'($urandom_range(1)), COORD_W'($urandom), COORD_W'($urandom),
                              AXIS_W'($urandom), AXIS_W'($urandom));
            end else begin
                size_pick = $urandom_range(99);
                if (size_pick < 80) begin
                    a = AXIS_W'($urandom_range(20));
                    b = AXIS_W'($urandom_range(20));
                end else if (size_pick < 95) begin
                    a = AXIS_W'($urandom_range(120));
                    b = AXIS_W'($urandom_range(120));
                end else begin
                    a = AXIS_W'($urandom);
                    b = AXIS_W'($urandom);
                end
                if (pick < 30 || size_pick >= 95)
                    run_drawing(COORD_W'($urandom), COORD_W'($urandom), a, b,
                                $urandom_range(30, 1));
                else
                    run_drawing(COORD_W'($urandom), COORD_W'($urandom), a, b, 1000);
                if ($urandom_range(99) < 30)
                    repeat ($urandom_range(2, 1)) send_step();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_step();
        test_extremes();
        test_degenerate();
        test_region_one_end();
        test_region_change();
        test_restart();
        wait_drained();
        test_backpressure();

        tx_idle_pct = 13;
        rx_idle_pct = 67;
        test_random_drawings(200);
        tx_idle_pct = 67;
        rx_idle_pct = 13;
        test_random_drawings(200);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_drawings(200);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
